FILE: hdl/dgbl_pkg.sv
// ----------------------------------------------------------------------------
// dgbl_pkg
// Shared widths, defaults and the control struct of the directivity grid
// lookup pipeline.
// ----------------------------------------------------------------------------
package dgbl_pkg;

    localparam int NUM_BANDS_DEF     = 32;
    localparam int AZIMUTH_STEPS_DEF = 72;
    localparam int POLAR_STEPS_DEF   = 37;

    localparam int FRAC_BITS  = 8;
    localparam int VALUE_BITS = 16;
    localparam int BAND_W     = 5;
    localparam int AZ_W       = 15;
    localparam int POL_W      = 14;

    // Weights run from 0 to one whole unit, so they need one bit above the fraction.
    localparam int WGT_W = FRAC_BITS + 1;
    localparam int VA_W  = VALUE_BITS + WGT_W + 2;
    localparam int ACC_W = VA_W + WGT_W + 2;

    typedef struct packed {
        logic query;
        logic ok;
        logic load;
    } t_ctl;

endpackage

FILE: hdl/dgbl_if.sv
// ----------------------------------------------------------------------------
// dgbl_in_if / dgbl_out_if
// Valid/ready channels for query and load words and for result words.
// ----------------------------------------------------------------------------
interface dgbl_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [4:0]                 band;
    logic [14:0]                azimuth;
    logic [13:0]                polar;
    logic signed [15:0]         load_value;

    modport source (output valid, mode, band, azimuth, polar, load_value, input ready);
    modport sink   (input valid, mode, band, azimuth, polar, load_value, output ready);
endinterface

interface dgbl_out_if;
    logic                       valid;
    logic                       ready;
    logic signed [15:0]         value;
    logic                       valid_res;

    modport source (output valid, value, valid_res, input ready);
    modport sink   (input valid, value, valid_res, output ready);
endinterface

FILE: hdl/dgbl_addr.sv
// ----------------------------------------------------------------------------
// dgbl_addr
// Decodes a word into neighbour indices and weights, keeps the loaded-band
// mask, then forms the four read addresses and the write address.
// ----------------------------------------------------------------------------
module dgbl_addr
    import dgbl_pkg::*;
#(
    parameter int NUM_BANDS     = NUM_BANDS_DEF,
    parameter int AZIMUTH_STEPS = AZIMUTH_STEPS_DEF,
    parameter int POLAR_STEPS   = POLAR_STEPS_DEF,
    parameter int MAW           = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic                         i_mode,
    input  logic [BAND_W-1:0]            i_band,
    input  logic [AZ_W-1:0]              i_azimuth,
    input  logic [POL_W-1:0]             i_polar,
    input  logic signed [VALUE_BITS-1:0] i_load_value,
    output logic                         o_valid,
    output t_ctl                         o_ctl,
    output logic [FRAC_BITS-1:0]         o_t,
    output logic [WGT_W-1:0]             o_u,
    output logic [3:0][MAW-1:0]          o_raddr,
    output logic [MAW-1:0]               o_waddr,
    output logic signed [VALUE_BITS-1:0] o_wdata
);

    localparam int AW = (AZIMUTH_STEPS > 1) ? $clog2(AZIMUTH_STEPS) : 1;
    localparam int PW = (POLAR_STEPS > 1) ? $clog2(POLAR_STEPS) : 1;
    localparam int RW = $clog2(NUM_BANDS * AZIMUTH_STEPS + 1);

    logic [AZ_W-FRAC_BITS-1:0]  a_int;
    logic [POL_W-FRAC_BITS-1:0] p_int;
    logic [AW-1:0]              a0, a1;
    logic [AW:0]                a_inc;
    logic [PW-1:0]              p0;
    logic [WGT_W-1:0]           u;
    logic                       band_ok, loaded, az_ok, pol_ok, load_ok;
    t_ctl                       ctl;
    logic [NUM_BANDS-1:0]       r_band_loaded, n_band_loaded;

    logic                       r1_valid;
    t_ctl                       r1_ctl;
    logic [RW-1:0]              r1_row0, r1_row1;
    logic [PW-1:0]              r1_p0, r1_lp;
    logic [FRAC_BITS-1:0]       r1_t;
    logic [WGT_W-1:0]           r1_u;
    logic signed [VALUE_BITS-1:0] r1_wdata;

    logic                       r2_valid;
    t_ctl                       r2_ctl;
    logic [FRAC_BITS-1:0]       r2_t;
    logic [WGT_W-1:0]           r2_u;
    logic [3:0][MAW-1:0]        r2_raddr;
    logic [MAW-1:0]             r2_waddr;
    logic signed [VALUE_BITS-1:0] r2_wdata;

    always_comb begin
        a_int   = i_azimuth[AZ_W-1:FRAC_BITS];
        p_int   = i_polar[POL_W-1:FRAC_BITS];
        band_ok = 32'(i_band) < NUM_BANDS;
        loaded  = |(r_band_loaded & (NUM_BANDS'(1) << i_band));
        az_ok   = 32'(i_azimuth) <= (AZIMUTH_STEPS << FRAC_BITS);
        pol_ok  = 32'(i_polar) <= ((POLAR_STEPS - 1) << FRAC_BITS);
        // Azimuth 360 degrees is the same column as 0.
        a0      = (32'(a_int) >= AZIMUTH_STEPS) ? '0 : AW'(32'(a_int));
        a_inc   = {1'b0, a0} + (AW+1)'(1);
        a1      = (32'(a_inc) >= AZIMUTH_STEPS) ? '0 : a_inc[AW-1:0];
        // At the top row the blend stays in the last cell with full upper weight.
        if (32'(p_int) >= POLAR_STEPS - 1) begin
            p0 = PW'(POLAR_STEPS - 2);
            u  = WGT_W'(1) << FRAC_BITS;
        end else begin
            p0 = PW'(32'(p_int));
            u  = {1'b0, i_polar[FRAC_BITS-1:0]};
        end
        load_ok = i_mode && band_ok && (32'(a_int) <= AZIMUTH_STEPS)
                  && (32'(p_int) < POLAR_STEPS);
        ctl.query = !i_mode;
        ctl.ok    = !i_mode && band_ok && loaded && az_ok && pol_ok;
        ctl.load  = load_ok;
        n_band_loaded = r_band_loaded;
        if (i_valid && i_en && load_ok) begin
            n_band_loaded = r_band_loaded | (NUM_BANDS'(1) << i_band);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_loaded <= '0;
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
        end else begin
            r_band_loaded <= n_band_loaded;
            if (i_en) begin
                r1_valid <= i_valid;
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl   <= ctl;
            r1_row0  <= RW'(32'(i_band) * AZIMUTH_STEPS + 32'(a0));
            r1_row1  <= RW'(32'(i_band) * AZIMUTH_STEPS + 32'(a1));
            r1_p0    <= p0;
            r1_lp    <= PW'(32'(p_int));
            r1_t     <= i_azimuth[FRAC_BITS-1:0];
            r1_u     <= u;
            r1_wdata <= i_load_value;

            r2_ctl      <= r1_ctl;
            r2_t        <= r1_t;
            r2_u        <= r1_u;
            r2_raddr[0] <= MAW'(32'(r1_row0) * POLAR_STEPS + 32'(r1_p0));
            r2_raddr[1] <= MAW'(32'(r1_row0) * POLAR_STEPS + 32'(r1_p0) + 1);
            r2_raddr[2] <= MAW'(32'(r1_row1) * POLAR_STEPS + 32'(r1_p0));
            r2_raddr[3] <= MAW'(32'(r1_row1) * POLAR_STEPS + 32'(r1_p0) + 1);
            r2_waddr    <= MAW'(32'(r1_row0) * POLAR_STEPS + 32'(r1_lp));
            r2_wdata    <= r1_wdata;
        end
    end

    assign o_valid = r2_valid;
    assign o_ctl   = r2_ctl;
    assign o_t     = r2_t;
    assign o_u     = r2_u;
    assign o_raddr = r2_raddr;
    assign o_waddr = r2_waddr;
    assign o_wdata = r2_wdata;

endmodule

FILE: hdl/dgbl_mem.sv
// ----------------------------------------------------------------------------
// dgbl_mem
// Four copies of the grid, each written by every load and read at one of
// the four neighbour addresses, with registered read data.
// ----------------------------------------------------------------------------
module dgbl_mem
    import dgbl_pkg::*;
#(
    parameter int DEPTH = NUM_BANDS_DEF * AZIMUTH_STEPS_DEF * POLAR_STEPS_DEF,
    parameter int MAW   = 17
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic                               i_we,
    input  logic [MAW-1:0]                     i_waddr,
    input  logic signed [VALUE_BITS-1:0]       i_wdata,
    input  logic [3:0][MAW-1:0]                i_raddr,
    output logic [3:0][VALUE_BITS-1:0]         o_rdata
);

    for (genvar g = 0; g < 4; g++) begin : g_copy
        logic [VALUE_BITS-1:0] mem [DEPTH];
        logic [VALUE_BITS-1:0] r_rdata;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_we) begin
                    mem[i_waddr] <= i_wdata;
                end
                r_rdata <= mem[i_raddr[g]];
            end
        end

        assign o_rdata[g] = r_rdata;
    end

endmodule

FILE: hdl/dgbl_blend.sv
// ----------------------------------------------------------------------------
// dgbl_blend
// Polar blend of both columns, azimuth blend, then rounding half up and
// saturation into the result register.
// ----------------------------------------------------------------------------
module dgbl_blend
    import dgbl_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_ctl                         i_ctl,
    input  logic [FRAC_BITS-1:0]         i_t,
    input  logic [WGT_W-1:0]             i_u,
    input  logic [3:0][VALUE_BITS-1:0]   i_cell,
    output logic                         o_valid,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic                         o_valid_res
);

    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;
    localparam int               RW  = ACC_W - 2 * FRAC_BITS;
    localparam logic signed [RW-1:0] VMAX = RW'((1 << (VALUE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] VMIN = -RW'(1 << (VALUE_BITS - 1));

    logic                      r4_valid, r5_valid, r6_valid;
    t_ctl                      r4_ctl, r5_ctl;
    logic [FRAC_BITS-1:0]      r4_t;
    logic signed [VA_W-1:0]    r4_va, r4_vb;
    logic signed [ACC_W-1:0]   r5_acc;
    logic signed [VALUE_BITS-1:0] r6_value;
    logic                      r6_res;

    logic signed [WGT_W:0]     wu0, wu1, wt0, wt1;
    logic signed [ACC_W-1:0]   acc_r;
    logic signed [RW-1:0]      shifted;
    logic signed [VALUE_BITS-1:0] sat;

    always_comb begin
        wu0     = $signed({1'b0, ONE - i_u});
        wu1     = $signed({1'b0, i_u});
        wt0     = $signed({1'b0, ONE - {1'b0, r4_t}});
        wt1     = $signed({2'b0, r4_t});
        acc_r   = r5_acc + ACC_W'(1 << (2 * FRAC_BITS - 1));
        shifted = RW'(acc_r >>> (2 * FRAC_BITS));
        if (shifted > VMAX) begin
            sat = VMAX[VALUE_BITS-1:0];
        end else if (shifted < VMIN) begin
            sat = VMIN[VALUE_BITS-1:0];
        end else begin
            sat = shifted[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid && i_ctl.query;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctl <= i_ctl;
            r4_t   <= i_t;
            r4_va  <= VA_W'(wu0 * $signed(i_cell[0])) + VA_W'(wu1 * $signed(i_cell[1]));
            r4_vb  <= VA_W'(wu0 * $signed(i_cell[2])) + VA_W'(wu1 * $signed(i_cell[3]));
            r5_ctl <= r4_ctl;
            r5_acc <= ACC_W'(wt0 * r4_va) + ACC_W'(wt1 * r4_vb);
            r6_res   <= r5_ctl.ok;
            r6_value <= r5_ctl.ok ? sat : '0;
        end
    end

    assign o_valid     = r6_valid;
    assign o_value     = r6_value;
    assign o_valid_res = r6_res;

endmodule

FILE: hdl/directivity_grid_bilinear_lookup.sv
// ----------------------------------------------------------------------------
// directivity_grid_bilinear_lookup
// Per-band attenuation grid with bilinear lookup over a 5-degree sphere.
// ----------------------------------------------------------------------------
// Usage: words arrive on i_in. A load word (mode 1) writes one grid point of
// a band and marks the band loaded; it gives no result. A query word (mode 0)
// gives exactly one result word on o_out: the rounded, saturated blend of the
// four neighbouring points, or value 0 with valid_res 0 for an unloaded band
// or an angle off the sphere.
// Throughput is one word per cycle while o_out is not stalled. A query passes six
// register stages: decode, address multiply, grid read, polar blend, azimuth
// blend, round and saturate. The first stage loads at the accepting edge, and
// the result is taken from the round-and-saturate register.
// Each load is written to four grid copies so that the four neighbours are
// read in parallel.
// Reset clears the loaded-band mask and all pipeline valid bits; the grid
// contents are undefined until written, and a band must be fully loaded
// before it is queried. When the receiver holds ready low with a result
// waiting, the whole pipeline holds and i_in.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module directivity_grid_bilinear_lookup
    import dgbl_pkg::*;
#(
    parameter int NUM_BANDS     = NUM_BANDS_DEF,
    parameter int AZIMUTH_STEPS = AZIMUTH_STEPS_DEF,
    parameter int POLAR_STEPS   = POLAR_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dgbl_in_if.sink     i_in,
    dgbl_out_if.source  o_out
);

    localparam int DEPTH = NUM_BANDS * AZIMUTH_STEPS * POLAR_STEPS;
    localparam int MAW   = $clog2(DEPTH);

    logic                         en;
    logic                         s2_valid;
    t_ctl                         s2_ctl;
    logic [FRAC_BITS-1:0]         s2_t;
    logic [WGT_W-1:0]             s2_u;
    logic [3:0][MAW-1:0]          s2_raddr;
    logic [MAW-1:0]               s2_waddr;
    logic signed [VALUE_BITS-1:0] s2_wdata;
    logic [3:0][VALUE_BITS-1:0]   s3_cell;

    logic                         r3_valid;
    t_ctl                         r3_ctl;
    logic [FRAC_BITS-1:0]         r3_t;
    logic [WGT_W-1:0]             r3_u;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    dgbl_addr #(
        .NUM_BANDS     (NUM_BANDS),
        .AZIMUTH_STEPS (AZIMUTH_STEPS),
        .POLAR_STEPS   (POLAR_STEPS),
        .MAW           (MAW)
    ) u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in.valid),
        .i_mode       (i_in.mode),
        .i_band       (i_in.band),
        .i_azimuth    (i_in.azimuth),
        .i_polar      (i_in.polar),
        .i_load_value (i_in.load_value),
        .o_valid      (s2_valid),
        .o_ctl        (s2_ctl),
        .o_t          (s2_t),
        .o_u          (s2_u),
        .o_raddr      (s2_raddr),
        .o_waddr      (s2_waddr),
        .o_wdata      (s2_wdata)
    );

    dgbl_mem #(
        .DEPTH (DEPTH),
        .MAW   (MAW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (s2_valid && s2_ctl.load),
        .i_waddr (s2_waddr),
        .i_wdata (s2_wdata),
        .i_raddr (s2_raddr),
        .o_rdata (s3_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ctl <= s2_ctl;
            r3_t   <= s2_t;
            r3_u   <= s2_u;
        end
    end

    dgbl_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r3_valid),
        .i_ctl       (r3_ctl),
        .i_t         (r3_t),
        .i_u         (r3_u),
        .i_cell      (s3_cell),
        .o_valid     (o_out.valid),
        .o_value     (o_out.value),
        .o_valid_res (o_out.valid_res)
    );

endmodule

FILE: hdl/dgbl_checker.sv
// ----------------------------------------------------------------------------
// dgbl_checker
// Port-level checks of the lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module dgbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_value,
    input logic        i_out_valid_res
);

    // A word rejected for range or loading always carries a zero value.
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_valid_res |-> i_out_value == 16'd0)
        else $error("invalid result carries a nonzero value");

    // The pipeline takes input exactly when its result register can move.
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not match output stall");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result changed");

endmodule

bind directivity_grid_bilinear_lookup dgbl_checker u_dgbl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_value     (o_out.value),
    .i_out_valid_res (o_out.valid_res)
);
